/* rtl/bmh_pkg.sv */
// bmh_pkg: field widths, status codes and the command type shared by the
// heap front end and engine
// no dependencies
package bmh_pkg;

  localparam int unsigned VAL_W  = 31;  // heap value width
  localparam int unsigned CNT_W  = 11;  // reported entry count width
  localparam int unsigned STAT_W = 2;   // status width

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_EXTRACT = 1'b1;

  // classified operation handed from the front end to the engine
  typedef enum logic [1:0] {
    CMD_INS,
    CMD_INS_FULL,
    CMD_EXT,
    CMD_EXT_EMPTY
  } cmd_e;

  typedef struct packed {
    cmd_e             kind;
    logic [VAL_W-1:0] value;
  } cmd_t;

endpackage

/* rtl/bmh_if.sv */
// bmh_in_if / bmh_out_if: valid/ready channels of the heap
// depends on bmh_pkg

interface bmh_in_if import bmh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [VAL_W-1:0] value_in;

  modport source (output valid, output func, output value_in, input ready);
  modport sink   (input valid, input func, input value_in, output ready);
endinterface

interface bmh_out_if import bmh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [VAL_W-1:0]  max_value;
  logic [CNT_W-1:0]  entry_count;

  modport source (output valid, output status, output max_value, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input max_value, input entry_count,
                  output ready);
endinterface

/* rtl/bmh_ram.sv */
// bmh_ram: generic single-write, dual-read ram with registered read data
// no dependencies
module bmh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

/* rtl/bmh_front.sv */
// bmh_front: accepts words, tracks the entry count and classifies each
// operation as insert, full insert, extract or empty extract
// depends on bmh_pkg and bmh_in_if
module bmh_front import bmh_pkg::*; #(
  parameter int unsigned Capacity = 1024,
  parameter int unsigned CntW     = $clog2(Capacity + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  bmh_in_if.sink          in_i,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output cmd_t            cmd_o,
  output logic [CntW-1:0] cmd_cnt_o,
  output logic [CntW-1:0] count_o
);

  logic [CntW-1:0] count_q, count_d;
  logic            accept;

  assign in_i.ready  = cmd_ready_i;
  assign cmd_valid_o = in_i.valid;
  assign accept      = in_i.valid && cmd_ready_i;
  assign count_o     = count_q;

  always_comb begin
    cmd_o.value = in_i.value_in;
    if (in_i.func == FUNC_INSERT) begin
      if (count_q == CntW'(Capacity)) begin
        cmd_o.kind = CMD_INS_FULL;
        cmd_cnt_o  = count_q;
      end else begin
        cmd_o.kind = CMD_INS;
        cmd_cnt_o  = count_q + CntW'(1);
      end
    end else begin
      if (count_q == '0) begin
        cmd_o.kind = CMD_EXT_EMPTY;
        cmd_cnt_o  = count_q;
      end else begin
        cmd_o.kind = CMD_EXT;
        cmd_cnt_o  = count_q - CntW'(1);
      end
    end
    count_d = accept ? cmd_cnt_o : count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

/* rtl/bmh_cmdq.sv */
// bmh_cmdq: two-entry fifo between the front end and the engine
// no dependencies
module bmh_cmdq #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  logic [Width-1:0] slot_q [2];
  logic             wr_q, wr_d, rd_q, rd_d;
  logic [1:0]       fill_q, fill_d;
  logic             push, pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_data_o   = slot_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d   = push ? !wr_q : wr_q;
    rd_d   = pop ? !rd_q : rd_q;
    fill_d = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/bmh_engine.sv */
// bmh_engine: carries out heap commands on the heap ram, one tree level per
// cycle, and holds the result register
// depends on bmh_pkg, bmh_out_if and bmh_ram
module bmh_engine import bmh_pkg::*; #(
  parameter int unsigned Capacity = 1024,
  parameter int unsigned CntW     = $clog2(Capacity + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  cmd_t            cmd_i,
  input  logic [CntW-1:0] cmd_cnt_i,
  bmh_out_if.source       out_o
);

  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned ChW  = IdxW + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CMP,
    S_DN_LOAD,
    S_DN_CMP,
    S_FIN
  } state_e;

  state_e            state_q, state_d;
  logic [IdxW-1:0]   pos_q, pos_d;
  logic [CntW-1:0]   n_q, n_d;
  logic [VAL_W-1:0]  v_q, v_d;
  logic              ov_q, ov_d;
  logic [STAT_W-1:0] ost_q, ost_d;
  logic [VAL_W-1:0]  omax_q, omax_d;
  logic [CNT_W-1:0]  ocnt_q, ocnt_d;

  // ram port
  logic              we;
  logic [IdxW-1:0]   waddr, raddr_a, raddr_b;
  logic [VAL_W-1:0]  wdata, rdata_a, rdata_b;

  logic              out_free;
  logic [IdxW-1:0]   ins_pos, ins_par, pos_par, par_par, pick_idx;
  logic [ChW-1:0]    l_w, r_w, n_w, nl_w, nr_w;
  logic              r_ok, pick_r, nl_ok;
  logic [VAL_W-1:0]  pick_v;
  logic [CntW+CNT_W-1:0] cmd_cnt_ext, n_ext;

  bmh_ram #(
    .Width (VAL_W),
    .Depth (Capacity)
  ) u_heap_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  assign out_free    = !ov_q || out_o.ready;
  assign cmd_ready_o = (state_q == S_IDLE) && out_free;

  assign out_o.valid       = ov_q;
  assign out_o.status      = ost_q;
  assign out_o.max_value   = omax_q;
  assign out_o.entry_count = ocnt_q;

  // count to reported width, zero padded then masked
  assign cmd_cnt_ext = {{CNT_W{1'b0}}, cmd_cnt_i};
  assign n_ext       = {{CNT_W{1'b0}}, n_q};

  // sift-up addressing
  assign ins_pos = IdxW'(cmd_cnt_i - CntW'(1));
  assign ins_par = (ins_pos - IdxW'(1)) >> 1;
  assign pos_par = (pos_q - IdxW'(1)) >> 1;
  assign par_par = (pos_par - IdxW'(1)) >> 1;

  // sift-down child selection, right child wins a tie
  assign l_w      = {1'b0, pos_q, 1'b1};
  assign r_w      = l_w + ChW'(1);
  assign n_w      = ChW'(n_q);
  assign r_ok     = r_w < n_w;
  assign pick_r   = r_ok && !(rdata_b < rdata_a);
  assign pick_v   = pick_r ? rdata_b : rdata_a;
  assign pick_idx = pick_r ? r_w[IdxW-1:0] : l_w[IdxW-1:0];
  assign nl_w     = {1'b0, pick_idx, 1'b1};
  assign nr_w     = nl_w + ChW'(1);
  assign nl_ok    = nl_w < n_w;

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    n_d         = n_q;
    v_d         = v_q;
    ov_d        = ov_q && !out_o.ready;
    ost_d       = ost_q;
    omax_d      = omax_q;
    ocnt_d      = ocnt_q;
    we          = 1'b0;
    waddr       = pos_q;
    wdata       = v_q;
    raddr_a     = pos_par;
    raddr_b     = IdxW'(n_q);

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          case (cmd_i.kind)
            CMD_INS_FULL: begin
              ov_d   = 1'b1;
              ost_d  = ST_FULL;
              omax_d = '0;
              ocnt_d = cmd_cnt_ext[CNT_W-1:0];
            end
            CMD_EXT_EMPTY: begin
              ov_d   = 1'b1;
              ost_d  = ST_EMPTY;
              omax_d = '0;
              ocnt_d = cmd_cnt_ext[CNT_W-1:0];
            end
            CMD_INS: begin
              // result is known up front, the sift runs behind it
              ov_d   = 1'b1;
              ost_d  = ST_OK;
              omax_d = '0;
              ocnt_d = cmd_cnt_ext[CNT_W-1:0];
              v_d    = cmd_i.value;
              pos_d  = ins_pos;
              if (ins_pos == '0) begin
                we    = 1'b1;
                waddr = '0;
                wdata = cmd_i.value;
              end else begin
                raddr_a = ins_par;
                state_d = S_UP_CMP;
              end
            end
            default: begin
              // extract: fetch root and last entry
              n_d     = cmd_cnt_i;
              raddr_a = '0;
              raddr_b = IdxW'(cmd_cnt_i);
              state_d = S_DN_LOAD;
            end
          endcase
        end
      end
      S_UP_CMP: begin
        if (v_q > rdata_a) begin
          we    = 1'b1;
          wdata = rdata_a;
          pos_d = pos_par;
          if (pos_par == '0) begin
            state_d = S_FIN;
          end else begin
            raddr_a = par_par;
          end
        end else begin
          we      = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DN_LOAD: begin
        ov_d   = 1'b1;
        ost_d  = ST_OK;
        omax_d = rdata_a;
        ocnt_d = n_ext[CNT_W-1:0];
        v_d    = rdata_b;
        pos_d  = '0;
        if (n_q == '0) begin
          state_d = S_IDLE;
        end else if (n_q == CntW'(1)) begin
          we      = 1'b1;
          waddr   = '0;
          wdata   = rdata_b;
          state_d = S_IDLE;
        end else begin
          raddr_a = IdxW'(1);
          raddr_b = IdxW'(2);
          state_d = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (pick_v > v_q) begin
          we    = 1'b1;
          wdata = pick_v;
          pos_d = pick_idx;
          if (nl_ok) begin
            raddr_a = nl_w[IdxW-1:0];
            raddr_b = nr_w[IdxW-1:0];
          end else begin
            state_d = S_FIN;
          end
        end else begin
          we      = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_FIN: begin
        we      = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pos_q   <= '0;
      n_q     <= '0;
      v_q     <= '0;
      ov_q    <= 1'b0;
      ost_q   <= '0;
      omax_q  <= '0;
      ocnt_q  <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      n_q     <= n_d;
      v_q     <= v_d;
      ov_q    <= ov_d;
      ost_q   <= ost_d;
      omax_q  <= omax_d;
      ocnt_q  <= ocnt_d;
    end
  end

endmodule

/* rtl/binary_max_heap.sv */
// binary_max_heap: max-heap priority queue, top level
// depends on bmh_pkg, bmh_if, bmh_front, bmh_cmdq, bmh_engine (bmh_ram)
//
//   channel   dir   word fields                          accepted when
//   in_i      in    func, value_in                       valid && ready
//   out_o     out   status, max_value, entry_count       valid && ready
//
// one result word per input word, in order
// full insert and empty extract set the result word without the ram; insert
//   sets it as the command starts, then sifts up; extract reads the root and
//   last entry, sets it, then sifts down; a walk spans at most log2(CAPACITY)
//   levels plus closing write; one level per cycle, one write and two read ports
// the front end counts entries and classifies words, so input keeps flowing
//   into the two-word command queue while the engine sifts
// the engine starts a command only when the result register is free, and
//   input stalls only when the queue is full
// reset (async, active low) clears the count, queue and engine; the heap ram
//   needs no clearing since read data is only used from live entries
module binary_max_heap import bmh_pkg::*; #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bmh_in_if.sink    in_i,
  bmh_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned QW   = $bits(cmd_t) + CntW;

  // front end to queue
  logic            fq_valid, fq_ready;
  cmd_t            fq_cmd;
  logic [CntW-1:0] fq_cnt;
  logic [CntW-1:0] front_cnt;

  // queue to engine
  logic            qe_valid, qe_ready;
  logic [QW-1:0]   qe_data;
  cmd_t            qe_cmd;
  logic [CntW-1:0] qe_cnt;

  bmh_front #(
    .Capacity (CAPACITY),
    .CntW     (CntW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (fq_valid),
    .cmd_ready_i (fq_ready),
    .cmd_o       (fq_cmd),
    .cmd_cnt_o   (fq_cnt),
    .count_o     (front_cnt)
  );

  bmh_cmdq #(
    .Width (QW)
  ) u_cmdq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  ({fq_cmd, fq_cnt}),
    .pop_valid_o  (qe_valid),
    .pop_ready_i  (qe_ready),
    .pop_data_o   (qe_data)
  );

  assign qe_cmd = qe_data[QW-1:CntW];
  assign qe_cnt = qe_data[CntW-1:0];

  bmh_engine #(
    .Capacity (CAPACITY),
    .CntW     (CntW)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (qe_valid),
    .cmd_ready_o (qe_ready),
    .cmd_i       (qe_cmd),
    .cmd_cnt_i   (qe_cnt),
    .out_o       (out_o)
  );

`ifndef NO_ASSERTIONS
  // tracked entry count never passes capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_cnt <= CntW'(CAPACITY))
    else $error("heap entry count above capacity");

  // a command is only started when its result has somewhere to go
  a_pop_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (qe_valid && qe_ready) |-> (!out_o.valid || out_o.ready))
    else $error("command started while result register busy");

  // empty extract reports nothing held and no value
  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == ST_EMPTY) |->
      (out_o.entry_count == '0 && out_o.max_value == '0))
    else $error("empty status with nonzero payload");

  // full status reports a heap at capacity and no value
  a_full_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == ST_FULL) |->
      (out_o.entry_count == CNT_W'(CAPACITY) && out_o.max_value == '0))
    else $error("full status with wrong payload");
`endif

endmodule

/* tb/sv/testbench.sv */
// testbench: self-checking bench for the binary_max_heap priority queue
// depends on bmh_pkg, bmh_if and the binary_max_heap top level with its submodules
// drives insert/extract words, predicts every result word and compares field by field

module testbench;
  import bmh_pkg::*;

  localparam int unsigned HEAP_CAP    = 1024;    // capacity of the instance under test
  localparam int unsigned HOLD_CYCLES = 1500;    // length of the long receiver hold-off
  localparam int unsigned TAIL_CYCLES = 32;      // settle time after the last result
  localparam int unsigned CYCLE_LIMIT = 600000;  // timeout, many times the slowest run
  localparam int unsigned DRAIN_WORDS = 120;     // extracts at the end of the run

  // one predicted result word
  typedef struct packed {
    status_e          status;
    logic [VAL_W-1:0] max_value;
    logic [CNT_W-1:0] entry_count;
  } heap_result_t;

  logic clk_i;
  logic rst_ni;

  bmh_in_if  in_if ();
  bmh_out_if out_if ();

  binary_max_heap #(
    .CAPACITY (HEAP_CAP)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // predicted heap contents and fill level, updated as each word is accepted
  logic [VAL_W-1:0] heap_model [HEAP_CAP];
  int unsigned      heap_fill = 0;

  // results predicted but not yet seen at the output, oldest first
  heap_result_t pending_results [$];

  int unsigned fail_count     = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;  // chance per cycle that the sender stays idle
  int unsigned recv_stall_pct = 0;  // chance per cycle that the receiver stalls

  // long hold-off of the receiver, raised once and counted in its own process
  logic        hold_go    = 1'b0;
  int unsigned hold_count = 0;

  // clock, period 12
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // timeout guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // hold-off counter: runs once hold_go is raised, saturates at HOLD_CYCLES
  always @(posedge clk_i) begin
    if (hold_go && hold_count < HOLD_CYCLES) begin
      hold_count <= hold_count + 1;
    end
  end

  // reference behavior of the heap: returns the result of one word and
  // updates the predicted heap
  function automatic heap_result_t heap_predict(input logic op, input logic [VAL_W-1:0] val);
    heap_result_t     res;
    int unsigned      pos;
    int unsigned      up;
    int unsigned      lc;
    int unsigned      rc;
    int unsigned      pick;
    logic [VAL_W-1:0] tmp;
    bit               done;
    res.status    = ST_OK;
    res.max_value = '0;
    done          = 1'b0;
    if (op == FUNC_INSERT) begin
      if (heap_fill >= HEAP_CAP) begin
        // full heap: word dropped, nothing changes
        res.status = ST_FULL;
      end else begin
        pos = heap_fill;
        heap_model[pos] = val;
        heap_fill++;
        // sift up while strictly greater than the parent
        while (!done && pos > 0) begin
          up = (pos - 1) >> 1;
          if (heap_model[pos] > heap_model[up]) begin
            tmp             = heap_model[pos];
            heap_model[pos] = heap_model[up];
            heap_model[up]  = tmp;
            pos             = up;
          end else begin
            done = 1'b1;
          end
        end
      end
    end else begin
      if (heap_fill == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.max_value = heap_model[0];
        heap_fill--;
        heap_model[0] = heap_model[heap_fill];
        // sift down: larger child, right child on a tie, swap only if strictly greater
        pos = 0;
        while (!done) begin
          lc = 2 * pos + 1;
          rc = lc + 1;
          if (lc >= heap_fill) begin
            done = 1'b1;
          end else begin
            if (rc >= heap_fill) pick = lc;
            else if (heap_model[rc] < heap_model[lc]) pick = lc;
            else pick = rc;
            if (heap_model[pick] > heap_model[pos]) begin
              tmp              = heap_model[pos];
              heap_model[pos]  = heap_model[pick];
              heap_model[pick] = tmp;
              pos              = pick;
            end else begin
              done = 1'b1;
            end
          end
        end
      end
    end
    res.entry_count = heap_fill[CNT_W-1:0];
    return res;
  endfunction

  // random value: extremes, a narrow range that makes ties likely, or any value
  function automatic logic [VAL_W-1:0] rand_value();
    int unsigned      sel;
    logic [VAL_W-1:0] val;
    logic [31:0]      raw;
    sel = $urandom_range(0, 99);
    raw = $urandom;
    if (sel < 5) val = '0;
    else if (sel < 10) val = '1;
    else if (sel < 35) val = VAL_W'(raw[3:0]);
    else val = raw[VAL_W-1:0];
    return val;
  endfunction

  // send one word: random idle gap, then hold valid until ready; the
  // prediction is made at the accepting edge
  task automatic send_word(input logic op, input logic [VAL_W-1:0] val);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.func     <= op;
    in_if.value_in <= val;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    pending_results.push_back(heap_predict(op, val));
  endtask

  // random mix of inserts and extracts with random values
  task automatic send_random(input int unsigned count, input int unsigned insert_pct);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < insert_pct) send_word(FUNC_INSERT, rand_value());
      else send_word(FUNC_EXTRACT, rand_value());
    end
  endtask

  // extremes, bit patterns, ties and extract on an empty heap
  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_word(FUNC_EXTRACT, '1);  // empty heap right after reset
    send_word(FUNC_INSERT, '0);
    send_word(FUNC_INSERT, '1);
    send_word(FUNC_INSERT, 31'h5555_5555);
    send_word(FUNC_INSERT, 31'h2AAA_AAAA);
    send_word(FUNC_INSERT, '1);   // equal to the root
    send_word(FUNC_INSERT, 31'd7);
    repeat (6) send_word(FUNC_EXTRACT, '0);
    // equal children under the root: right child taken
    send_word(FUNC_INSERT, 31'd9);
    send_word(FUNC_INSERT, 31'd5);
    send_word(FUNC_INSERT, 31'd5);
    send_word(FUNC_INSERT, 31'd1);
    repeat (4) send_word(FUNC_EXTRACT, 31'h7FFF_0000);
    send_word(FUNC_EXTRACT, '0);  // empty again
  endtask

  // random traffic under each idling pattern
  task automatic test_random_mix();
    send_idle_pct  = 0;  recv_stall_pct = 0;
    send_random(110, 60);
    send_idle_pct  = 59; recv_stall_pct = 0;
    send_random(110, 55);
    send_idle_pct  = 0;  recv_stall_pct = 59;
    send_random(110, 60);
    send_idle_pct  = 22; recv_stall_pct = 22;
    send_random(110, 55);
  endtask

  // receiver holds off while the sender keeps pushing inserts until the
  // heap is at capacity; the queue fills and input must stall
  task automatic test_backpressure_fill();
    send_idle_pct  = 0;
    recv_stall_pct = 22;
    hold_go <= 1'b1;
    while (heap_fill < HEAP_CAP) send_word(FUNC_INSERT, rand_value());
  endtask

  // inserts into a full heap are dropped; churn around the capacity
  task automatic test_full_heap();
    send_idle_pct  = 22;
    recv_stall_pct = 22;
    send_word(FUNC_INSERT, '1);
    send_word(FUNC_INSERT, '0);
    send_word(FUNC_INSERT, 31'h5555_5555);
    send_word(FUNC_INSERT, 31'h2AAA_AAAA);
    send_random(60, 50);
  endtask

  // long run of extracts from a nearly full heap, deep sift-down walks
  task automatic test_drain();
    send_idle_pct  = 22;
    recv_stall_pct = 22;
    repeat (DRAIN_WORDS) send_word(FUNC_EXTRACT, rand_value());
    send_word(FUNC_EXTRACT, '0);
    send_word(FUNC_EXTRACT, '1);
  endtask

  // receiver: checks each accepted result word against the oldest prediction
  // and draws ready for the next cycle
  initial begin
    heap_result_t exp_res;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result word: status %0d max_value %0d entry_count %0d",
                 out_if.status, out_if.max_value, out_if.entry_count);
          fail_count++;
        end else begin
          exp_res = pending_results.pop_front();
          if (out_if.status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, out_if.status);
            fail_count++;
          end
          if (out_if.max_value !== exp_res.max_value) begin
            $error("max_value: expected %0d, got %0d", exp_res.max_value, out_if.max_value);
            fail_count++;
          end
          if (out_if.entry_count !== exp_res.entry_count) begin
            $error("entry_count: expected %0d, got %0d",
                   exp_res.entry_count, out_if.entry_count);
            fail_count++;
          end
        end
      end
      out_if.ready <= !(hold_go && hold_count < HOLD_CYCLES) &&
                      ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // main sequence
  initial begin
    rst_ni         <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.func     <= FUNC_INSERT;
    in_if.value_in <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_mix();
    test_backpressure_fill();
    test_full_heap();
    test_drain();

    // last word accepted in this step, so valid is lowered only once here
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
